FILE: rtl/bffa_pkg.sv
// Shared constants, codes and types of the bitmap first-fit frame allocator.
package bffa_pkg;

   localparam int FRAME_COUNT = 32768;
   localparam int WORD_BITS   = 64;
   localparam int MAP_WORDS   = FRAME_COUNT / WORD_BITS;
   localparam int ADDR_W      = $clog2(MAP_WORDS);
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int FRAME_W     = 15;
   localparam int COUNT_W     = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int LANE_BITS   = 8;
   localparam int LANE_W      = $clog2(LANE_BITS);

   typedef logic [FRAME_W-1:0] frame_type;
   typedef logic [COUNT_W-1:0] count_type;

   localparam logic OP_ALLOC  = 1'b0;
   localparam logic OP_FREE   = 1'b1;
   localparam logic ST_OK     = 1'b0;
   localparam logic ST_NOMEM  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_ALLOC_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ALLOC_TOP  = 2'd1;

   localparam count_type ALLOC_BASE_RESET = '0;
   localparam count_type ALLOC_TOP_RESET  = count_type'(FRAME_COUNT);

   typedef enum logic [1:0] {
      KIND_ALLOC,
      KIND_ALLOC_ZERO,
      KIND_FREE
   } kind_type;

   typedef struct packed {
      kind_type  kind;
      frame_type start;
      count_type count;
   } cmd_type;

   typedef struct packed {
      logic take;
      logic ready;
   } back_stat_type;

endpackage

FILE: rtl/bffa_front.sv
// Front end: accepts requests, classifies them and queues them for the engine.
module bffa_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_operation,
   input  bffa_pkg::frame_type   req_first_frame,
   input  bffa_pkg::count_type   req_frame_count,
   output logic                  cmd_valid,
   output bffa_pkg::cmd_type     cmd,
   input  bffa_pkg::back_stat_type back_stat
);
   import bffa_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    new_cmd;
   logic       push, pop;

   assign req_full  = (cnt_ff == 2'd2) | ~back_stat.ready;
   assign push      = req_push & ~req_full;
   assign pop       = back_stat.take & (cnt_ff != 2'd0);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ff];

   always_comb begin
      new_cmd.start = req_first_frame;
      new_cmd.count = req_frame_count;
      if (req_operation == OP_FREE) begin
         new_cmd.kind = KIND_FREE;
      end else if (req_frame_count == '0) begin
         new_cmd.kind = KIND_ALLOC_ZERO;
      end else begin
         new_cmd.kind = KIND_ALLOC;
      end
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= new_cmd;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: rtl/bffa_back.sv
// Engine: clears the bitmap, runs the first-fit search, marks runs and queues results.
module bffa_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   input  bffa_pkg::cmd_type       cmd,
   output bffa_pkg::back_stat_type back_stat,
   input  bffa_pkg::count_type     alloc_base,
   input  bffa_pkg::count_type     alloc_top,
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output bffa_pkg::frame_type     rsp_granted_start,
   output logic                    rsp_status
);
   import bffa_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_BYTE, S_MARK_RD, S_MARK_WR, S_DONE
   } state_type;

   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];

   state_type            state_ff, state_in;
   logic [ADDR_W:0]      wptr_ff, wptr_in;
   count_type            pos_ff, pos_in;
   count_type            run_ff, run_in;
   count_type            count_ff, count_in;
   count_type            lo_ff, lo_in;
   count_type            hi_ff, hi_in;
   logic                 set_ff, set_in;
   frame_type            res_start_ff, res_start_in;
   logic                 res_status_ff, res_status_in;
   logic [WORD_BITS-1:0] word_ff;

   frame_type            rq_start_ff [2];
   logic                 rq_status_ff [2];
   logic                 rq_wr_ff, rq_rd_ff;
   logic [1:0]           rq_cnt_ff;

   logic                 mem_we, mem_re;
   logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
   logic [WORD_BITS-1:0] mem_wdata, mask;
   logic                 take, res_push, res_pop;
   logic [COUNT_W:0]     free_sum;
   count_type            limit, free_hi, next_pos, mark_hi;
   count_type            r, fstart, f;
   logic                 found, fail;
   logic [ADDR_W:0]      wnext;

   assign limit = (alloc_top > count_type'(FRAME_COUNT)) ? count_type'(FRAME_COUNT)
                                                         : alloc_top;
   // The end of a free may run past the map; the sum keeps its carry.
   assign free_sum = {2'b00, cmd.start} + {1'b0, cmd.count};
   assign free_hi  = (free_sum > (COUNT_W+1)'(FRAME_COUNT)) ? count_type'(FRAME_COUNT)
                                                            : free_sum[COUNT_W-1:0];
   assign next_pos = {pos_ff[COUNT_W-1:LANE_W] + 1'b1, {LANE_W{1'b0}}};
   assign wnext    = wptr_ff + 1'b1;
   assign mark_hi  = fstart + count_ff;

   // One byte of the fetched word per cycle while in the byte-scan state, starting at the scan position.
   always_comb begin
      r      = run_ff;
      found  = 1'b0;
      fail   = 1'b0;
      fstart = '0;
      f      = '0;
      for (int k = 0; k < LANE_BITS; k++) begin
         f = {pos_ff[COUNT_W-1:LANE_W], LANE_W'(k)};
         if (!found && !fail && (LANE_W'(k) >= pos_ff[LANE_W-1:0])) begin
            if (f >= limit) begin
               fail = 1'b1;
            end else if (word_ff[{pos_ff[BIT_W-1:LANE_W], LANE_W'(k)}]) begin
               r = '0;
            end else begin
               r = r + 1'b1;
               if (r == count_ff) begin
                  found  = 1'b1;
                  fstart = f - count_ff + 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      mask = '1;
      if (wptr_ff[ADDR_W-1:0] == lo_ff[FRAME_W-1:BIT_W]) begin
         mask = mask & ({WORD_BITS{1'b1}} << lo_ff[BIT_W-1:0]);
      end
      if (wptr_ff == hi_ff[COUNT_W-1:BIT_W]) begin
         mask = mask & ~({WORD_BITS{1'b1}} << hi_ff[BIT_W-1:0]);
      end
   end

   always_comb begin
      state_in      = state_ff;
      wptr_in       = wptr_ff;
      pos_in        = pos_ff;
      run_in        = run_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      set_in        = set_ff;
      res_start_in  = res_start_ff;
      res_status_in = res_status_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = wptr_ff[ADDR_W-1:0];
      mem_raddr     = wptr_ff[ADDR_W-1:0];
      mem_wdata     = '0;
      take          = 1'b0;
      res_push      = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we  = 1'b1;
            wptr_in = wnext;
            if (wptr_ff[ADDR_W-1:0] == ADDR_W'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_valid && (rq_cnt_ff != 2'd2)) begin
               take          = 1'b1;
               count_in      = cmd.count;
               res_start_in  = '0;
               res_status_in = ST_OK;
               unique case (cmd.kind)
                  KIND_ALLOC_ZERO: begin
                     res_start_in = alloc_base[FRAME_W-1:0];
                     state_in     = S_DONE;
                  end
                  KIND_FREE: begin
                     lo_in   = count_type'({1'b0, cmd.start});
                     hi_in   = free_hi;
                     set_in  = 1'b0;
                     wptr_in = {1'b0, cmd.start[FRAME_W-1:BIT_W]};
                     state_in = (free_hi > count_type'({1'b0, cmd.start})) ? S_MARK_RD
                                                                            : S_DONE;
                  end
                  KIND_ALLOC: begin
                     pos_in = alloc_base;
                     run_in = '0;
                     if (alloc_base >= limit) begin
                        res_status_in = ST_NOMEM;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SCAN_RD: begin
            mem_re    = 1'b1;
            mem_raddr = pos_ff[FRAME_W-1:BIT_W];
            state_in  = S_SCAN_BYTE;
         end
         S_SCAN_BYTE: begin
            run_in = r;
            if (found) begin
               lo_in         = fstart;
               hi_in         = mark_hi;
               set_in        = 1'b1;
               res_start_in  = fstart[FRAME_W-1:0];
               res_status_in = ST_OK;
               wptr_in       = {1'b0, fstart[FRAME_W-1:BIT_W]};
               state_in      = S_MARK_RD;
            end else if (fail || (next_pos >= limit)) begin
               res_start_in  = '0;
               res_status_in = ST_NOMEM;
               state_in      = S_DONE;
            end else begin
               pos_in = next_pos;
               if (next_pos[BIT_W-1:0] == '0) begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_MARK_RD: begin
            mem_re   = 1'b1;
            state_in = S_MARK_WR;
         end
         S_MARK_WR: begin
            mem_we    = 1'b1;
            mem_wdata = set_ff ? (word_ff | mask) : (word_ff & ~mask);
            wptr_in   = wnext;
            state_in  = ({wnext, {BIT_W{1'b0}}} >= hi_ff) ? S_DONE : S_MARK_RD;
         end
         S_DONE: begin
            res_push = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign back_stat.take  = take;
   assign back_stat.ready = (state_ff != S_CLEAR);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         word_ff <= map_mem[mem_raddr];
      end
   end

   assign res_pop           = rsp_pop & (rq_cnt_ff != 2'd0);
   assign rsp_empty         = (rq_cnt_ff == 2'd0);
   assign rsp_granted_start = rq_start_ff[rq_rd_ff];
   assign rsp_status        = rq_status_ff[rq_rd_ff];

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      run_ff        <= run_in;
      count_ff      <= count_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      set_ff        <= set_in;
      res_start_ff  <= res_start_in;
      res_status_ff <= res_status_in;
      if (res_push) begin
         rq_start_ff[rq_wr_ff]  <= res_start_ff;
         rq_status_ff[rq_wr_ff] <= res_status_ff;
      end
      if (reset) begin
         state_ff  <= S_CLEAR;
         wptr_ff   <= '0;
         rq_wr_ff  <= 1'b0;
         rq_rd_ff  <= 1'b0;
         rq_cnt_ff <= 2'd0;
      end else begin
         state_ff  <= state_in;
         wptr_ff   <= wptr_in;
         rq_wr_ff  <= rq_wr_ff ^ res_push;
         rq_rd_ff  <= rq_rd_ff ^ res_pop;
         rq_cnt_ff <= rq_cnt_ff + {1'b0, res_push} - {1'b0, res_pop};
      end
   end

endmodule

FILE: rtl/bitmap_first_fit_frame_allocator.sv
// Top level of the bitmap first-fit frame allocator: range registers, front end and engine.
//
//   Channel   Handshake                      Beat carries
//   req       req_push / req_full            operation, first_frame, frame_count
//   rsp       rsp_pop / rsp_empty            granted_start, status
//   csr       csr_valid / csr_ready          register index, write data
//
// After reset the engine clears the 512-word bitmap memory, one word per cycle, and
// req_full stays high until it is done; range register writes are taken meanwhile.
// An allocate fetches each bitmap word it reaches and scans it byte by byte, then
// reads and writes back each word of the run that it marks.
// A free reads and writes back each bitmap word it touches; a zero-count request
// goes straight to its result. The engine works on one request at a time.
// Requests and results each wait in a two-deep queue, so either side may stall
// without losing a beat.
module bitmap_first_fit_frame_allocator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic                           req_operation,
   input  bffa_pkg::frame_type            req_first_frame,
   input  bffa_pkg::count_type            req_frame_count,
   input  logic                           rsp_pop,
   output logic                           rsp_empty,
   output bffa_pkg::frame_type            rsp_granted_start,
   output logic                           rsp_status,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bffa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bffa_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bffa_pkg::*;

   count_type     alloc_base_ff;
   count_type     alloc_top_ff;
   logic          cmd_valid;
   cmd_type       cmd;
   back_stat_type back_stat;

   // The range registers accept a write in every cycle; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_base_ff <= ALLOC_BASE_RESET;
         alloc_top_ff  <= ALLOC_TOP_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_ALLOC_BASE) begin
            alloc_base_ff <= csr_wdata;
         end
         if (csr_index == REG_ALLOC_TOP) begin
            alloc_top_ff <= csr_wdata;
         end
      end
   end

   // Front end sorts each request into allocate, zero-count allocate or free.
   bffa_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_operation   (req_operation),
      .req_first_frame (req_first_frame),
      .req_frame_count (req_frame_count),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .back_stat       (back_stat)
   );

   // Engine owns the bitmap and the result queue.
   bffa_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .back_stat         (back_stat),
      .alloc_base        (alloc_base_ff),
      .alloc_top         (alloc_top_ff),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_granted_start (rsp_granted_start),
      .rsp_status        (rsp_status)
   );

   // While the bitmap is being cleared no request may enter.
   a_full_while_clearing: assert property (@(posedge clock) disable iff (reset)
      !back_stat.ready |-> req_full)
      else $error("request accepted while the bitmap is being cleared");

   // A failed allocation always reports frame zero.
   a_nomem_start_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == ST_NOMEM) |-> (rsp_granted_start == '0))
      else $error("failed allocation reports a non-zero start");

   // Reset leaves no result waiting.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result waiting right after reset");

   // The engine only takes a command that the front end offers.
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      back_stat.take |-> cmd_valid)
      else $error("engine took a command from an empty queue");

endmodule
